FILE: rtl/ps2_mouse_packet_tracker_macros.svh
// Assertion macros for the mouse packet tracker top level.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef PS2_MOUSE_PACKET_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_MACROS_SVH

// Same-cycle implication.
`define PS2MT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define PS2MT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/ps2mt_pkg.sv
// Package for the PS/2 mouse packet tracker: payload types, codes and constants.
// No dependencies; every other RTL module imports it.
`timescale 1ns / 1ps
`default_nettype none

package ps2mt_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int REG_W          = 12;

  localparam int SYNC_BIT_IDX  = 3;
  localparam int LEFT_BIT_IDX  = 0;
  localparam int RIGHT_BIT_IDX = 1;

  localparam int X_MAX_RST = 319;
  localparam int Y_MAX_RST = 199;
  localparam int X_POS_RST = 160;
  localparam int Y_POS_RST = 100;

  typedef enum logic [0:0] {
    CFG_X_MAX = 1'b0,
    CFG_Y_MAX = 1'b1
  } cfg_idx_t;

  // Position of the next byte inside a three-byte packet.
  typedef enum logic [1:0] {
    SLOT_HEAD = 2'd0,
    SLOT_DX   = 2'd1,
    SLOT_DY   = 2'd2
  } slot_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       from_aux;
  } in_t;

  typedef struct packed {
    logic             packet_done;
    logic [REG_W-1:0] pos_x;
    logic [REG_W-1:0] pos_y;
    logic             left_button;
    logic             right_button;
  } out_t;

  // Status from the tracker core toward the top level.
  typedef struct packed {
    slot_t slot;
  } trk_status_t;

endpackage

`default_nettype wire

FILE: rtl/ps2mt_in_stage.sv
// Input register stage of the PS/2 mouse packet tracker.
// Depends on ps2mt_pkg for the input payload type.
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ps2mt_pkg::in_t in_payload,
  input  wire logic          take,
  output logic               hold_valid,
  output ps2mt_pkg::in_t     hold_payload
);
  import ps2mt_pkg::*;

  logic valid_r;
  in_t  data_r;
  logic accept;

  // The held request leaves when downstream takes it, so a new one may
  // enter in the same cycle.
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_payload;
    end
  end

  assign hold_valid   = valid_r;
  assign hold_payload = data_r;

endmodule

`default_nettype wire

FILE: rtl/ps2mt_tracker.sv
// Packet assembly, position update with clamping, and limit registers.
// Depends on ps2mt_pkg for types, codes and reset constants.
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_tracker #(
  parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire ps2mt_pkg::cfg_idx_t      cfg_index,
  input  wire logic [ps2mt_pkg::REG_W-1:0] cfg_wdata,
  input  wire logic                     step,
  input  wire ps2mt_pkg::in_t           item,
  output ps2mt_pkg::out_t               result,
  output ps2mt_pkg::trk_status_t        status
);
  import ps2mt_pkg::*;

  localparam int SW = COORD_BITS + 2;
  localparam int EW = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;

  logic [REG_W-1:0]      x_max_r, y_max_r;
  slot_t                 slot_r, slot_nxt;
  logic [7:0]            header_r, header_nxt;
  logic [7:0]            dx_r, dx_nxt;
  logic [COORD_BITS-1:0] x_pos_r, x_pos_nxt;
  logic [COORD_BITS-1:0] y_pos_r, y_pos_nxt;
  logic                  left_r, left_nxt;
  logic                  right_r, right_nxt;
  logic                  done;

  logic [EW-1:0]         x_lim_ext, y_lim_ext;
  logic [COORD_BITS-1:0] x_lim, y_lim;
  logic signed [SW-1:0]  x_sum, y_sum;
  logic [COORD_BITS-1:0] x_clamped, y_clamped;
  logic [EW-1:0]         x_out_ext, y_out_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_max_r <= REG_W'(X_MAX_RST);
      y_max_r <= REG_W'(Y_MAX_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_MAX: x_max_r <= cfg_wdata;
        CFG_Y_MAX: y_max_r <= cfg_wdata;
        default:   x_max_r <= x_max_r;
      endcase
    end
  end

  // Limits are zero-extended or cut to the coordinate width.
  assign x_lim_ext = EW'(x_max_r);
  assign y_lim_ext = EW'(y_max_r);
  assign x_lim     = x_lim_ext[COORD_BITS-1:0];
  assign y_lim     = y_lim_ext[COORD_BITS-1:0];

  // X moves by the stored delta, Y against the delta of this byte.
  assign x_sum = $signed({2'b00, x_pos_r}) + SW'($signed(dx_r));
  assign y_sum = $signed({2'b00, y_pos_r}) - SW'($signed(item.rx_byte));

  always_comb begin
    if (x_sum[SW-1]) begin
      x_clamped = '0;
    end else if (x_sum[SW-2:0] > (COORD_BITS+1)'(x_lim)) begin
      x_clamped = x_lim;
    end else begin
      x_clamped = x_sum[COORD_BITS-1:0];
    end
    if (y_sum[SW-1]) begin
      y_clamped = '0;
    end else if (y_sum[SW-2:0] > (COORD_BITS+1)'(y_lim)) begin
      y_clamped = y_lim;
    end else begin
      y_clamped = y_sum[COORD_BITS-1:0];
    end
  end

  // Next packet slot.
  always_comb begin
    slot_nxt = slot_r;
    if (step && item.from_aux) begin
      unique case (slot_r)
        SLOT_HEAD: if (item.rx_byte[SYNC_BIT_IDX]) slot_nxt = SLOT_DX;
        SLOT_DX:   slot_nxt = SLOT_DY;
        default:   slot_nxt = SLOT_HEAD;
      endcase
    end
  end

  // Data registers and the completion flag.
  always_comb begin
    header_nxt = header_r;
    dx_nxt     = dx_r;
    x_pos_nxt  = x_pos_r;
    y_pos_nxt  = y_pos_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    done       = 1'b0;
    if (step && item.from_aux) begin
      unique case (slot_r)
        SLOT_HEAD: if (item.rx_byte[SYNC_BIT_IDX]) header_nxt = item.rx_byte;
        SLOT_DX:   dx_nxt = item.rx_byte;
        default: begin
          x_pos_nxt = x_clamped;
          y_pos_nxt = y_clamped;
          left_nxt  = header_r[LEFT_BIT_IDX];
          right_nxt = header_r[RIGHT_BIT_IDX];
          done      = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= SLOT_HEAD;
      header_r <= '0;
      dx_r     <= '0;
      x_pos_r  <= COORD_BITS'(X_POS_RST);
      y_pos_r  <= COORD_BITS'(Y_POS_RST);
      left_r   <= 1'b0;
      right_r  <= 1'b0;
    end else begin
      slot_r   <= slot_nxt;
      header_r <= header_nxt;
      dx_r     <= dx_nxt;
      x_pos_r  <= x_pos_nxt;
      y_pos_r  <= y_pos_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
    end
  end

  assign x_out_ext = EW'(x_pos_nxt);
  assign y_out_ext = EW'(y_pos_nxt);

  always_comb begin
    result.packet_done  = done;
    result.pos_x        = x_out_ext[REG_W-1:0];
    result.pos_y        = y_out_ext[REG_W-1:0];
    result.left_button  = left_nxt;
    result.right_button = right_nxt;
  end

  assign status.slot = slot_r;

endmodule

`default_nettype wire

FILE: rtl/ps2mt_out_stage.sv
// Result register of the PS/2 mouse packet tracker.
// Depends on ps2mt_pkg for the result payload type.
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_out_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            src_valid,
  output logic                 load,
  input  wire ps2mt_pkg::out_t src_payload,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ps2mt_pkg::out_t      out_payload
);
  import ps2mt_pkg::*;

  logic valid_r;
  out_t data_r;

  // The register can take a new result when empty or being drained.
  assign load = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && src_valid) begin
      data_r <= src_payload;
    end
  end

  assign out_valid   = valid_r;
  assign out_payload = data_r;

endmodule

`default_nettype wire

FILE: rtl/ps2_mouse_packet_tracker.sv
// A request accepted into the input register is presented at out_valid from the result register.
// Throughput: one request per cycle, sustained, as long as out_stall stays low; the
// single compute pass between the input register and the result register sets it.
// Reset: rst_n is synchronous and active low; it empties both registers, sets the
// limits to 319 and 199, the position to 160/100, and clears buttons and packet slot.
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_mouse_packet_tracker_macros.svh"

module ps2_mouse_packet_tracker #(
  parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire ps2mt_pkg::cfg_idx_t         cfg_index,
  input  wire logic [ps2mt_pkg::REG_W-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire ps2mt_pkg::in_t              in_payload,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output ps2mt_pkg::out_t                  out_payload
);
  import ps2mt_pkg::*;

  // Each request passes through three parts: the input register holds the
  // byte, the tracker applies it to the packet state and computes the result
  // from the updated state, and the result register presents it. The state
  // advances in the same cycle as the byte moves into the result register,
  // so the order of results always follows the order of requests.

  logic        hold_valid;
  in_t         hold_payload;
  logic        out_load;
  logic        step;
  out_t        result;
  trk_status_t status;

  // A held request is processed exactly when the result register can take it.
  assign step = hold_valid && out_load;

  ps2mt_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_payload   (in_payload),
    .take         (out_load),
    .hold_valid   (hold_valid),
    .hold_payload (hold_payload)
  );

  // Bytes from the keyboard port pass through with the state unchanged.
  ps2mt_tracker #(
    .COORD_BITS (COORD_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (hold_payload),
    .result    (result),
    .status    (status)
  );

  ps2mt_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .src_valid   (hold_valid),
    .load        (out_load),
    .src_payload (result),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

  // The input side only stalls while a request waits in the input register.
  `PS2MT_ASSERT_IMP(a_stall_needs_held, in_stall, hold_valid)
  // A completed packet shows up as the next presented result.
  `PS2MT_ASSERT_NXT(a_done_presented, step && result.packet_done, out_valid && out_payload.packet_done)
  // After a completed packet the tracker waits for a new header.
  `PS2MT_ASSERT_NXT(a_done_rearms, step && result.packet_done, status.slot == SLOT_HEAD)

endmodule

`default_nettype wire
